[rtl/core/gbp_pkg.sv]
// Package: types, constants and codes shared by the grid boundary proximity core.
package gbp_pkg;

    localparam int COORD_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int DIM_W      = 9;
    localparam int RAD_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 15;

    localparam logic [DIM_W-1:0]  RST_MAP_WIDTH     = DIM_W'(256);
    localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT    = DIM_W'(256);
    localparam logic [RAD_W-1:0]  RST_NEAR_RADIUS   = RAD_W'(3);
    localparam logic [RAD_W-1:0]  RST_OFFSET_RADIUS = RAD_W'(1);

    localparam logic [CHAR_W-1:0] OPEN_CHAR = 8'h30;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic STS_OK      = 1'b0;
    localparam logic STS_OUTSIDE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH     = 2'd0,
        CFG_MAP_HEIGHT    = 2'd1,
        CFG_NEAR_RADIUS   = 2'd2,
        CFG_OFFSET_RADIUS = 2'd3
    } t_cfg_idx;

    // read order for one window cell: center, then its four neighbors
    typedef enum logic [2:0] {
        PH_CTR = 3'd0,
        PH_DN  = 3'd1,
        PH_UP  = 3'd2,
        PH_RT  = 3'd3,
        PH_LT  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              req_type;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CHAR_W-1:0]  cell_char;
    } t_in_beat;

    typedef struct packed {
        logic near_flag;
        logic offset_flag;
        logic status;
    } t_out_beat;

    typedef struct packed {
        logic take_in;
        logic init;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_query;
        logic in_map;
        logic last_issue;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/gbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gbp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/gbp_ctrl.sv]
// Controller: sequences input accept, window walk, drain and result load.
module gbp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gbp_pkg::t_dp_sts i_sts,
    output gbp_pkg::t_dp_cmd o_cmd
);
    import gbp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.in_is_query) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = i_sts.in_map ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.take_in = i_in_valid;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
            end
            S_DRAIN: begin
            end
            S_FINISH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/gbp_dpath.sv]
// Datapath: config registers, cell memory, window walker and flag accumulation.
module gbp_dpath #(
    parameter int MAX_WIDTH  = gbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = gbp_pkg::DEF_MAX_RADIUS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  gbp_pkg::t_in_beat                   i_in_data,
    input  gbp_pkg::t_dp_cmd                    i_cmd,
    output gbp_pkg::t_dp_sts                    o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gbp_pkg::t_out_beat                  o_out_data
);
    import gbp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0]   r_map_width;
    logic [DIM_W-1:0]   r_map_height;
    logic [RAD_W-1:0]   r_near_radius;
    logic [RAD_W-1:0]   r_offset_radius;

    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [RAD_W-1:0]   eff_rn;
    logic [RAD_W-1:0]   eff_ro;
    logic [RAD_W-1:0]   rm;
    logic               in_inside;

    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic               r_inside;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_c0;
    logic [COORD_W-1:0] r_c1;
    logic [COORD_W-1:0] r_r1;
    t_phase             r_phase;
    t_phase             n_phase;

    logic [COORD_W-1:0] lo_c;
    logic [COORD_W-1:0] lo_r;
    logic [COORD_W-1:0] hi_c;
    logic [COORD_W-1:0] hi_r;
    logic [DIM_W-1:0]   sum_c;
    logic [DIM_W-1:0]   sum_r;
    logic [DIM_W-1:0]   wm1;
    logic [DIM_W-1:0]   hm1;

    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic               nbv;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] cheb_d;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic               rd_bit;

    logic               r_tag_vld;
    t_phase             r_tag_ph;
    logic               r_tag_nbv;
    logic               r_tag_near;
    logic               r_tag_off;
    logic               r_ctr;
    logic               r_hit;
    logic               r_near;
    logic               r_off;
    logic               bz;

    logic               r_out_vld;
    t_out_beat          r_out;
    logic               out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= RST_MAP_WIDTH;
            r_map_height    <= RST_MAP_HEIGHT;
            r_near_radius   <= RST_NEAR_RADIUS;
            r_offset_radius <= RST_OFFSET_RADIUS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_WIDTH:     r_map_width     <= i_cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT:    r_map_height    <= i_cfg_data[DIM_W-1:0];
                CFG_NEAR_RADIUS:   r_near_radius   <= i_cfg_data[RAD_W-1:0];
                CFG_OFFSET_RADIUS: r_offset_radius <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        eff_w  = (int'(r_map_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : r_map_width;
        eff_h  = (int'(r_map_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_map_height;
        eff_rn = (int'(r_near_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_near_radius;
        eff_ro = (int'(r_offset_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_offset_radius;
        rm     = (eff_rn > eff_ro) ? eff_rn : eff_ro;
        in_inside = (DIM_W'(i_in_data.col) < eff_w) && (DIM_W'(i_in_data.row) < eff_h);
    end

    // window bounds, clipped to the map
    always_comb begin
        wm1   = eff_w - DIM_W'(1);
        hm1   = eff_h - DIM_W'(1);
        sum_c = DIM_W'(r_cx) + DIM_W'(rm);
        sum_r = DIM_W'(r_cy) + DIM_W'(rm);
        lo_c  = (r_cx > COORD_W'(rm)) ? r_cx - COORD_W'(rm) : '0;
        lo_r  = (r_cy > COORD_W'(rm)) ? r_cy - COORD_W'(rm) : '0;
        hi_c  = (sum_c < wm1) ? sum_c[COORD_W-1:0] : wm1[COORD_W-1:0];
        hi_r  = (sum_r < hm1) ? sum_r[COORD_W-1:0] : hm1[COORD_W-1:0];
    end

    // read address of the current phase; an off-map neighbor reads the center
    always_comb begin
        ax  = r_x;
        ay  = r_y;
        nbv = 1'b1;
        unique case (r_phase)
            PH_CTR: begin
            end
            PH_DN: begin
                nbv = (DIM_W'(r_y) + DIM_W'(1)) < eff_h;
                if (nbv) ay = r_y + COORD_W'(1);
            end
            PH_UP: begin
                nbv = (r_y != '0);
                if (nbv) ay = r_y - COORD_W'(1);
            end
            PH_RT: begin
                nbv = (DIM_W'(r_x) + DIM_W'(1)) < eff_w;
                if (nbv) ax = r_x + COORD_W'(1);
            end
            PH_LT: begin
                nbv = (r_x != '0);
                if (nbv) ax = r_x - COORD_W'(1);
            end
            default: begin
            end
        endcase
        rd_addr = AW'(int'(ay) * MAX_WIDTH + int'(ax));
        wr_addr = AW'(int'(i_in_data.row) * MAX_WIDTH + int'(i_in_data.col));
        wr_en   = i_cmd.take_in && (i_in_data.req_type == REQ_WRITE) && in_inside;
        dx      = (r_x > r_cx) ? r_x - r_cx : r_cx - r_x;
        dy      = (r_y > r_cy) ? r_y - r_cy : r_cy - r_y;
        cheb_d  = (dx > dy) ? dx : dy;
    end

    always_comb begin
        unique case (r_phase)
            PH_CTR:  n_phase = PH_DN;
            PH_DN:   n_phase = PH_UP;
            PH_UP:   n_phase = PH_RT;
            PH_RT:   n_phase = PH_LT;
            PH_LT:   n_phase = PH_CTR;
            default: n_phase = PH_CTR;
        endcase
    end

    gbp_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in_data.cell_char == OPEN_CHAR),
        .i_re    (i_cmd.issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_bit)
    );

    // walker
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cx     <= i_in_data.col;
            r_cy     <= i_in_data.row;
            r_inside <= in_inside;
        end
        if (i_cmd.init) begin
            r_x     <= lo_c;
            r_y     <= lo_r;
            r_c0    <= lo_c;
            r_c1    <= hi_c;
            r_r1    <= hi_r;
            r_phase <= PH_CTR;
        end else if (i_cmd.issue) begin
            r_phase <= n_phase;
            if (r_phase == PH_LT) begin
                if (r_x == r_c1) begin
                    r_x <= r_c0;
                    r_y <= r_y + COORD_W'(1);
                end else begin
                    r_x <= r_x + COORD_W'(1);
                end
            end
        end
    end

    // tag travels with each read to its returning data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_tag_ph   <= r_phase;
            r_tag_nbv  <= nbv;
            r_tag_near <= (cheb_d <= COORD_W'(eff_rn));
            r_tag_off  <= (cheb_d <= COORD_W'(eff_ro));
        end
    end

    assign bz = r_ctr & (r_hit | (r_tag_nbv & ~rd_bit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_near <= 1'b0;
            r_off  <= 1'b0;
        end else if (r_tag_vld) begin
            case (r_tag_ph) inside
                PH_CTR: begin
                    r_ctr <= rd_bit;
                    r_hit <= 1'b0;
                end
                PH_DN, PH_UP, PH_RT: begin
                    r_hit <= r_hit | (r_tag_nbv & ~rd_bit);
                end
                PH_LT: begin
                    r_near <= r_near | (bz & r_tag_near);
                    r_off  <= r_off | (bz & r_tag_off);
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.near_flag   <= r_near;
            r_out.offset_flag <= r_off;
            r_out.status      <= r_inside ? STS_OK : STS_OUTSIDE;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.in_is_query = (i_in_data.req_type == REQ_QUERY);
        o_sts.in_map      = r_inside;
        o_sts.last_issue  = (r_phase == PH_LT) && (r_x == r_c1) && (r_y == r_r1);
        o_sts.out_free    = out_free;
    end

endmodule

[rtl/core/grid_boundary_proximity_core.sv]
// Top level: grid boundary proximity core, controller plus datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes write and query beats.
// A write beat stores one cell ('0' means open); writes
// outside the configured map are dropped and give no result.
// A query beat gives one result beat on the output channel (o_out_valid /
// i_out_stall / o_out_data): near and offset flags, status 1 when the cell is
// outside the map. A query inside the map walks the clipped window of side up to
// 2R+1 (R the larger radius) and reads five cells of the single read port per
// window cell. A query outside the map skips the walk. One query is worked on
// at a time. The result sits in an output register; the next beat is accepted
// while it waits. A stalled receiver only holds a finished query before its
// result load. Configuration (i_cfg_we / i_cfg_index / i_cfg_data) must be
// written while idle by the user; the block itself does not enforce this.
// Reset (synchronous, active low) restores the register defaults and clears
// control state; cell memory content is undefined until written.
module grid_boundary_proximity_core #(
    parameter int MAX_WIDTH  = gbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gbp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = gbp_pkg::DEF_MAX_RADIUS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gbp_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gbp_pkg::t_out_beat             o_out_data
);
    import gbp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    gbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gbp_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
